// ----- sv/tacf_pkg.sv -----
// ---------------------------------------------------------------------------
// tacf_pkg - shared types and constants for the tilt angle filter
// Command/status structs between controller and datapath, CORDIC arctangent
// table and fixed-point constants.
// ---------------------------------------------------------------------------
`default_nettype none

package tacf_pkg;

   // angles in 1/256 degree saturate here (180 degrees)
   localparam int ANG_MAX    = 46080;
   // arctangent table length, and index width into it
   localparam int ATAN_LEN   = 24;
   localparam int IDX_W      = 5;
   // channel and register port widths
   localparam int IN_W       = 64;
   localparam int OUT_W      = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GYRO_OFS  = 2'd0,
      CSR_ACCEL_OFS = 2'd1,
      CSR_TIP_LIMIT = 2'd2
   } tacf_csr_type;

   // datapath phase after the CORDIC loop
   typedef enum logic [2:0] {
      PH_NONE,
      PH_CAL,
      PH_NUM,
      PH_WGT,
      PH_LP,
      PH_BLEND,
      PH_FUSE,
      PH_EMIT
   } tacf_phase_type;

   typedef struct packed {
      logic                 load;
      logic                 rot;
      logic [IDX_W-1:0]     rot_idx;
      tacf_phase_type       phase;
   } tacf_cmd_type;

   typedef struct packed {
      logic out_free;
   } tacf_sts_type;

   // atan(2^-i) in 1/65536 degree, rounded
   localparam logic signed [26:0] ATAN_Q16 [ATAN_LEN] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
      27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
      27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
      27'sd917,     27'sd458,     27'sd229,    27'sd115,
      27'sd57,      27'sd29,      27'sd14,     27'sd7,
      27'sd4,       27'sd2,       27'sd1,      27'sd0
   };

   // 180 degrees in 1/65536 degree
   localparam logic signed [26:0] HALF_TURN_Q16 = 27'sd11796480;

   // blend weight in 2^-24: base and cap
   localparam logic [19:0] W_BASE = 20'd83886;
   localparam logic [19:0] W_MAX  = 20'd335544;

   // reciprocals: ceil(2^33/125) and ceil(2^23/10)
   localparam logic signed [27:0] RECIP_125 = 28'sd68719477;
   localparam logic signed [27:0] RECIP_10  = 28'sd838861;

   // low-pass numerator bias keeps it positive: 10*46081 plus rounding 5
   localparam logic signed [23:0] LP_NUM_BIAS = 24'sd460815;
   localparam logic signed [23:0] LP_Q_BIAS   = 24'sd46081;

endpackage

`default_nettype wire

// ----- sv/tacf_ctrl.sv -----
// ---------------------------------------------------------------------------
// tacf_ctrl - sequencer for the tilt angle filter
// Accepts a word, runs the CORDIC iterations, then steps the datapath
// through calibration, gyro integration, blend weight, low-pass, blend and result load.
// ---------------------------------------------------------------------------
`default_nettype none

module tacf_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire tacf_pkg::tacf_sts_type sts,
   output tacf_pkg::tacf_cmd_type     cmd
);
   import tacf_pkg::*;

   localparam int ROT_N = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam logic [IDX_W-1:0] ROT_LAST = IDX_W'(ROT_N - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT,
      ST_CAL,
      ST_NUM,
      ST_WGT,
      ST_LP,
      ST_BLEND,
      ST_FUSE,
      ST_OUT
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] cnt_ff;

   // state and iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (req_tvalid) state_ff <= ST_ROT;
            end
            ST_ROT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ROT_LAST) state_ff <= ST_CAL;
            end
            ST_CAL:   state_ff <= ST_NUM;
            ST_NUM:   state_ff <= ST_WGT;
            ST_WGT:   state_ff <= ST_LP;
            ST_LP:    state_ff <= ST_BLEND;
            ST_BLEND: state_ff <= ST_FUSE;
            ST_FUSE:  state_ff <= ST_OUT;
            ST_OUT: begin
               if (sts.out_free) state_ff <= ST_IDLE;
            end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // no word taken while in reset
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   // command decode
   always_comb begin
      cmd.load    = req_tvalid && (state_ff == ST_IDLE) && !reset;
      cmd.rot     = (state_ff == ST_ROT);
      cmd.rot_idx = cnt_ff;
      unique case (state_ff)
         ST_CAL:   cmd.phase = PH_CAL;
         ST_NUM:   cmd.phase = PH_NUM;
         ST_WGT:   cmd.phase = PH_WGT;
         ST_LP:    cmd.phase = PH_LP;
         ST_BLEND: cmd.phase = PH_BLEND;
         ST_FUSE:  cmd.phase = PH_FUSE;
         ST_OUT:   cmd.phase = sts.out_free ? PH_EMIT : PH_NONE;
         default:  cmd.phase = PH_NONE;
      endcase
   end

   // result only loaded into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == PH_EMIT) |-> sts.out_free)
      else $error("result loaded while output register busy");

   // loop exits after the last iteration
   a_rot_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT && cnt_ff == ROT_LAST) |=> (state_ff == ST_CAL))
      else $error("CORDIC loop did not exit on last step");

   // an accepted word starts the loop at step zero
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_ROT && cnt_ff == '0))
      else $error("CORDIC loop not started from step zero");

endmodule

`default_nettype wire

// ----- sv/tacf_dpath.sv -----
// ---------------------------------------------------------------------------
// tacf_dpath - datapath of the tilt angle filter
// CORDIC vectoring unit, one shared registered multiplier, filter state,
// configuration registers and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tacf_dpath #(
   parameter int SAMPLE_PERIOD_MS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [tacf_pkg::IN_W-1:0]         req_tdata,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [tacf_pkg::OUT_W-1:0]             rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [tacf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [tacf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire tacf_pkg::tacf_cmd_type            cmd,
   output tacf_pkg::tacf_sts_type                 sts
);
   import tacf_pkg::*;

   // saturate to +-180 degrees in 1/256 degree
   function automatic logic signed [16:0] sat_ang(input logic signed [23:0] v);
      logic signed [16:0] r;
      if (v > 24'sd46080)       r = 17'sd46080;
      else if (v < -24'sd46080) r = -17'sd46080;
      else                      r = v[16:0];
      return r;
   endfunction

   // configuration
   logic signed [15:0] gofs_ff;
   logic signed [16:0] aofs_ff;
   logic [15:0]        tip_ff;

   // filter state
   logic signed [16:0] fused_ff, fused_in;
   logic signed [16:0] lp_ff, lp_in;
   logic               run_ff, run_in;

   // per-sample working registers
   logic signed [34:0] x_ff, x_in;
   logic signed [34:0] y_ff, y_in;
   logic signed [26:0] z_ff, z_in;
   logic               ax_zero_ff, ax_zero_in;
   logic               az_neg_ff, az_neg_in;
   logic signed [15:0] rate_ff, rate_in;
   logic [15:0]        mag_ff, mag_in;
   logic signed [16:0] cal_ff, cal_in;
   logic signed [16:0] ang_ff, ang_in;
   logic [18:0]        w_ff, w_in;
   logic [19:0]        num_ff, num_in;
   logic signed [55:0] prod_ff;
   logic signed [27:0] mul_a, mul_b;

   // output register
   logic               rsp_tvalid_ff;
   logic [OUT_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // input fields
   logic signed [15:0] ax_s, az_s, gy_s, diff_s;
   assign ax_s   = $signed(req_tdata[15:0]);
   assign az_s   = $signed(req_tdata[31:16]);
   assign gy_s   = $signed(req_tdata[47:32]);
   assign diff_s = $signed(req_tdata[63:48]);

   // helpers
   logic signed [34:0] x_load, y_load, xs, ys;
   logic signed [16:0] rate_sum, diff_abs;
   logic signed [27:0] zneg, tilt_r;
   logic signed [23:0] tilt, num_s, gp, inc;
   logic [19:0]        q125, wsum;
   logic [16:0]        q10, fmag;
   logic [24:0]        m125;
   logic signed [17:0] d;
   logic signed [39:0] br;
   logic               tip;

   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      x_load   = 35'(az_s) <<< 16;
      y_load   = 35'(ax_s) <<< 16;
      rate_sum = 17'(gy_s) + 17'(gofs_ff);
      diff_abs = diff_s[15] ? (17'sd0 - 17'(diff_s)) : 17'(diff_s);
      xs       = x_ff >>> cmd.rot_idx;
      ys       = y_ff >>> cmd.rot_idx;
      zneg     = 28'sd0 - 28'(z_ff);
      tilt_r   = (zneg + 28'sd128) >>> 8;
      if (ax_zero_ff) tilt = az_neg_ff ? -24'sd46080 : 24'sd0;
      else            tilt = 24'(tilt_r);
      num_s    = (24'(lp_ff) <<< 3) + (24'(cal_ff) <<< 1) + LP_NUM_BIAS;
      gp       = $signed(prod_ff[23:0]);
      inc      = (gp + 24'sd32) >>> 6;
      m125     = {mag_ff[9:0], 15'd0} + 25'd62;
      q125     = prod_ff[52:33];
      wsum     = W_BASE + q125;
      q10      = prod_ff[39:23];
      d        = 18'(lp_ff) - 18'(ang_ff);
      br       = $signed(prod_ff[39:0]) + 40'sd8388608;
      fmag     = fused_ff[16] ? (17'd0 - fused_ff) : fused_ff;
      tip      = run_ff && (fmag > {1'b0, tip_ff});
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.phase)
         PH_CAL: begin
            mul_a = 28'(rate_ff);
            mul_b = 28'(SAMPLE_PERIOD_MS);
         end
         PH_NUM: begin
            mul_a = $signed({3'd0, m125});
            mul_b = RECIP_125;
         end
         PH_WGT: begin
            mul_a = $signed({8'd0, num_ff});
            mul_b = RECIP_10;
         end
         PH_BLEND: begin
            mul_a = $signed({9'd0, w_ff});
            mul_b = 28'(d);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // next values
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      ax_zero_in   = ax_zero_ff;
      az_neg_in    = az_neg_ff;
      rate_in      = rate_ff;
      mag_in       = mag_ff;
      cal_in       = cal_ff;
      ang_in       = ang_ff;
      w_in         = w_ff;
      num_in       = num_ff;
      fused_in     = fused_ff;
      lp_in        = lp_ff;
      run_in       = run_ff;
      rsp_tdata_in = rsp_tdata_ff;

      // capture a word with the CORDIC pre-rotation into the right half plane
      if (cmd.load) begin
         ax_zero_in = (ax_s == 16'sd0);
         az_neg_in  = az_s[15];
         if (az_s[15]) begin
            x_in = 35'sd0 - x_load;
            y_in = 35'sd0 - y_load;
            z_in = (ax_s > 16'sd0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
         end else begin
            x_in = x_load;
            y_in = y_load;
            z_in = '0;
         end
         if (rate_sum > 17'sd32767)       rate_in = 16'sh7FFF;
         else if (rate_sum < -17'sd32768) rate_in = 16'sh8000;
         else                             rate_in = rate_sum[15:0];
         mag_in = diff_abs[15:0];
      end

      // one CORDIC vectoring step
      if (cmd.rot) begin
         if (!y_ff[34]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ATAN_Q16[cmd.rot_idx];
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ATAN_Q16[cmd.rot_idx];
         end
      end

      case (cmd.phase)
         PH_CAL: cal_in = sat_ang(tilt + 24'(aofs_ff));
         PH_NUM: begin
            num_in = num_s[19:0];
            ang_in = sat_ang(24'(fused_ff) + inc);
         end
         PH_WGT: begin
            if ((|mag_ff[15:10]) || (wsum > W_MAX)) w_in = W_MAX[18:0];
            else                                    w_in = wsum[18:0];
         end
         PH_LP:   lp_in = sat_ang($signed({7'd0, q10}) - LP_Q_BIAS);
         PH_FUSE: fused_in = sat_ang(24'(ang_ff) + 24'($signed(br[39:24])));
         PH_EMIT: begin
            run_in       = run_ff && !tip;
            rsp_tdata_in = {4'd0, tip, run_ff && !tip, lp_ff, fused_ff};
         end
         default: ;
      endcase
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      ax_zero_ff   <= ax_zero_in;
      az_neg_ff    <= az_neg_in;
      rate_ff      <= rate_in;
      mag_ff       <= mag_in;
      cal_ff       <= cal_in;
      ang_ff       <= ang_in;
      w_ff         <= w_in;
      num_ff       <= num_in;
      prod_ff      <= mul_a * mul_b;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // filter state, configuration and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fused_ff      <= '0;
         lp_ff         <= '0;
         run_ff        <= 1'b1;
         gofs_ff       <= '0;
         aofs_ff       <= '0;
         tip_ff        <= 16'd12800;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fused_ff <= fused_in;
         lp_ff    <= lp_in;
         run_ff   <= run_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_GYRO_OFS:  gofs_ff <= csr_wdata[15:0];
               CSR_ACCEL_OFS: aofs_ff <= csr_wdata;
               CSR_TIP_LIMIT: tip_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.phase == PH_EMIT) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready)      rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // low-pass state stays within +-180 degrees
   a_lp_range: assert property (@(posedge clock) disable iff (reset)
      (lp_ff <= 17'sd46080) && (lp_ff >= -17'sd46080))
      else $error("low-pass angle out of range");

   // run latch never sets again once cleared
   a_run_sticky: assert property (@(posedge clock) disable iff (reset)
      !run_ff |=> !run_ff)
      else $error("run latch set again after tip-over");

   // a tip-over word always reports not running
   a_tip_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[35]) |-> !rsp_tdata_ff[34])
      else $error("tip-over word reports running");

endmodule

`default_nettype wire

// ----- sv/tilt_angle_complementary_filter.sv -----
// ---------------------------------------------------------------------------
// tilt_angle_complementary_filter - fused tilt estimate for a balancing robot
// Accelerometer tilt by CORDIC atan2, low-passed, blended with the
// integrated gyro rate; a run latch clears once on tip-over.
//
//   port group | dir | payload
//   -----------+-----+-------------------------------------------------
//   req_*      | in  | accel_x, accel_z, gyro_y, wheel_speed_diff
//   rsp_*      | out | tilt_angle, filtered_accel_angle, running, tipped_now
//   csr_*      | in  | 0 gyro_rate_offset, 1 accel_angle_offset, 2 tip_limit
//
// After accept the result is valid once the CORDIC loop, one step per cycle,
// and then seven sequencer steps have run.
// A new word is taken once the previous result is in the output register.
// Reset is synchronous: angles go to zero, run latch set, tip limit 12800.
// A stalled output only holds the sequencer at its last step.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_angle_complementary_filter #(
   parameter int SAMPLE_PERIOD_MS = 10,
   parameter int CORDIC_STEPS     = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // accel_x[15:0], accel_z[31:16], gyro_y[47:32], wheel_speed_diff[63:48]
   input  wire logic [tacf_pkg::IN_W-1:0]         req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tilt_angle[16:0], filtered_accel_angle[33:17], running[34],
   // tipped_now[35], zero fill [39:36]
   output logic [tacf_pkg::OUT_W-1:0]             rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [tacf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [tacf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tacf_pkg::*;

   tacf_cmd_type cmd;
   tacf_sts_type sts;

   tacf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tacf_dpath #(
      .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire
